// ===== hw/rtl/defe_pkg.sv =====
// Shared types, widths and codes for the derivative and EMA feature estimator.
package defe_pkg;

  localparam int POS_W  = 32;            // positions and forces, Q16.16
  localparam int VAL_W  = 48;            // velocities and accelerations, Q16.16
  localparam int DIF_W  = 49;            // widest signed difference fed to the multiplier
  localparam int K_W    = 40;            // widest unsigned multiplier coefficient
  localparam int W_W    = 16;            // filter weight, Q1.15
  localparam int FERR_W = 33;            // force error
  localparam int LO_W   = 25;            // low slice of the operand magnitude
  localparam int HI_W   = DIF_W - LO_W;  // high slice of the operand magnitude
  localparam int PROD_W = DIF_W + K_W;   // full product magnitude

  // Item function codes
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_SEED   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_INV_STEP      = 2'd0;
  localparam logic [1:0] CFG_INV_STEP_SQ   = 2'd1;
  localparam logic [1:0] CFG_FILTER_WEIGHT = 2'd2;

  // Multiplier operations
  localparam logic [2:0] OP_VEL   = 3'd0;  // measured velocity
  localparam logic [2:0] OP_CACC  = 3'd1;  // raw commanded acceleration
  localparam logic [2:0] OP_ACC   = 3'd2;  // raw measured acceleration
  localparam logic [2:0] OP_EMA_M = 3'd3;  // filter step, measured acceleration
  localparam logic [2:0] OP_EMA_C = 3'd4;  // filter step, commanded acceleration

  // History update kinds at the end of a sample
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  localparam logic [31:0]       INV_STEP_RST    = 32'd65536000;
  localparam logic [39:0]       INV_STEP_SQ_RST = 40'd65536000000;
  localparam logic [W_W-1:0]    WEIGHT_ONE      = 16'd32768;
  localparam logic [VAL_W-1:0]  MAX48           = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0]  MIN48           = {1'b1, {(VAL_W-1){1'b0}}};

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;  // latch sample word
    logic       seed;     // preload history from the seed word
    logic       mul_ld;   // load multiplier operands
    logic       mul_lo;   // low partial product
    logic       mul_hi;   // high partial product, accumulate
    logic       mul_fin;  // round, saturate, register
    logic       wb;       // write multiplier result back
    logic [2:0] op;
    logic       done;     // update history and load the result word
    logic [1:0] kind;
  } cmd_t;

endpackage

// ===== hw/rtl/defe_mul.sv =====
// Shared two-pass multiplier with floor shift and 48-bit saturation.
module defe_mul
  import defe_pkg::*;
(
  input  logic                    clk,
  input  logic                    ld,
  input  logic                    lo,
  input  logic                    hi,
  input  logic                    fin,
  input  logic signed [DIF_W-1:0] a,
  input  logic [K_W-1:0]          k,
  input  logic                    shift15,
  output logic signed [VAL_W-1:0] res_sat,
  output logic signed [DIF_W-1:0] res_raw
);

  logic                   neg;
  logic [DIF_W-1:0]       mag;
  logic [K_W-1:0]         kreg;
  logic                   sh15;
  logic [PROD_W-1:0]      prod;
  logic [LO_W+K_W-1:0]    p_lo;
  logic [HI_W+K_W-1:0]    p_hi;
  logic [PROD_W-16:0]     q;
  logic [PROD_W-15:0]     qc;
  logic                   rem;
  logic [VAL_W-1:0]       sat_next;
  logic [DIF_W-1:0]       raw_next;

  always_comb begin
    p_lo = mag[LO_W-1:0] * kreg;
    p_hi = mag[DIF_W-1:LO_W] * kreg;
    if (sh15) begin
      q   = prod[PROD_W-1:15];
      rem = |prod[14:0];
    end else begin
      q   = {1'b0, prod[PROD_W-1:16]};
      rem = |prod[15:0];
    end
    qc = {1'b0, q} + {{(PROD_W-15){1'b0}}, rem};
    if (!neg) begin
      sat_next = (|q[PROD_W-16:VAL_W-1]) ? MAX48 : q[VAL_W-1:0];
      raw_next = q[DIF_W-1:0];
    end else begin
      // magnitude above 2^47 clamps to the most negative value
      if ((|qc[PROD_W-15:VAL_W]) || (qc[VAL_W-1] && (|qc[VAL_W-2:0]))) begin
        sat_next = MIN48;
      end else begin
        sat_next = (~qc[VAL_W-1:0]) + 1'b1;
      end
      raw_next = (~qc[DIF_W-1:0]) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      neg  <= a[DIF_W-1];
      mag  <= a[DIF_W-1] ? ((~a) + 1'b1) : a;
      kreg <= k;
      sh15 <= shift15;
    end
    if (lo) begin
      prod <= {{(PROD_W-LO_W-K_W){1'b0}}, p_lo};
    end else if (hi) begin
      prod <= prod + {p_hi, {LO_W{1'b0}}};
    end
    if (fin) begin
      res_sat <= sat_next;
      res_raw <= raw_next;
    end
  end

endmodule

// ===== hw/rtl/defe_dp.sv =====
// Datapath: configuration, history registers, operand selection and result word.
module defe_dp
  import defe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [K_W-1:0]           cfg_data,
  input  cmd_t                     cmd,
  input  logic signed [POS_W-1:0]  cmd_pos,
  input  logic signed [POS_W-1:0]  meas_pos,
  input  logic signed [VAL_W-1:0]  seed_vel,
  input  logic signed [POS_W-1:0]  force_target,
  input  logic signed [POS_W-1:0]  force_measured,
  output logic signed [VAL_W-1:0]  cmd_accel,
  output logic signed [VAL_W-1:0]  meas_vel,
  output logic signed [VAL_W-1:0]  meas_accel,
  output logic signed [FERR_W-1:0] force_error,
  output logic                     warmed_up
);

  logic [31:0]              inv_step;
  logic [K_W-1:0]           inv_step_sq;
  logic [W_W-1:0]           filter_weight;
  logic [W_W-1:0]           weight;

  logic signed [POS_W-1:0]  xc_in;
  logic signed [POS_W-1:0]  x_in;
  logic signed [POS_W-1:0]  ft_in;
  logic signed [POS_W-1:0]  fm_in;

  logic signed [POS_W-1:0]  cpl;
  logic signed [POS_W-1:0]  cpbl;
  logic signed [POS_W-1:0]  mpl;
  logic signed [VAL_W-1:0]  mvl;
  logic signed [VAL_W-1:0]  maf;
  logic signed [VAL_W-1:0]  caf;

  logic signed [VAL_W-1:0]  vel_r;
  logic signed [VAL_W-1:0]  acc_r;
  logic signed [VAL_W-1:0]  cacc_r;

  logic signed [DIF_W-1:0]  opa;
  logic [K_W-1:0]           opk;
  logic                     op_sh15;
  logic signed [VAL_W-1:0]  res_sat;
  logic signed [DIF_W-1:0]  res_raw;
  logic                     warm;

  always_comb begin
    weight  = (filter_weight > WEIGHT_ONE) ? WEIGHT_ONE : filter_weight;
    warm    = (cmd.kind == KIND_FULL);
    opk     = {{(K_W-32){1'b0}}, inv_step};
    op_sh15 = 1'b0;
    case (cmd.op)
      OP_VEL:  opa = DIF_W'(x_in) - DIF_W'(mpl);
      OP_CACC: begin
        opa = DIF_W'(xc_in) - (DIF_W'(cpl) <<< 1) + DIF_W'(cpbl);
        opk = inv_step_sq;
      end
      OP_ACC:  opa = DIF_W'(vel_r) - DIF_W'(mvl);
      OP_EMA_M: begin
        opa     = DIF_W'(acc_r) - DIF_W'(maf);
        opk     = {{(K_W-W_W){1'b0}}, weight};
        op_sh15 = 1'b1;
      end
      OP_EMA_C: begin
        opa     = DIF_W'(cacc_r) - DIF_W'(caf);
        opk     = {{(K_W-W_W){1'b0}}, weight};
        op_sh15 = 1'b1;
      end
      default: opa = '0;
    endcase
  end

  defe_mul u_mul (
    .clk     (clk),
    .ld      (cmd.mul_ld),
    .lo      (cmd.mul_lo),
    .hi      (cmd.mul_hi),
    .fin     (cmd.mul_fin),
    .a       (opa),
    .k       (opk),
    .shift15 (op_sh15),
    .res_sat (res_sat),
    .res_raw (res_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_step      <= INV_STEP_RST;
      inv_step_sq   <= INV_STEP_SQ_RST;
      filter_weight <= WEIGHT_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_STEP:      inv_step      <= cfg_data[31:0];
        CFG_INV_STEP_SQ:   inv_step_sq   <= cfg_data;
        CFG_FILTER_WEIGHT: filter_weight <= cfg_data[W_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xc_in <= cmd_pos;
      x_in  <= meas_pos;
      ft_in <= force_target;
      fm_in <= force_measured;
    end

    // old + floor(w * (raw - old) / 2^15) is the filter step
    if (cmd.wb) begin
      case (cmd.op)
        OP_VEL:   vel_r  <= res_sat;
        OP_CACC:  cacc_r <= res_sat;
        OP_ACC:   acc_r  <= res_sat;
        OP_EMA_M: acc_r  <= maf + res_raw[VAL_W-1:0];
        OP_EMA_C: cacc_r <= caf + res_raw[VAL_W-1:0];
        default: ;
      endcase
    end

    if (cmd.seed) begin
      cpl  <= cmd_pos;
      cpbl <= cmd_pos;
      mpl  <= meas_pos;
      mvl  <= seed_vel;
    end else if (cmd.done) begin
      case (cmd.kind)
        KIND_FIRST: begin
          cpl <= xc_in;
          mpl <= x_in;
          mvl <= '0;
        end
        KIND_SECOND: begin
          cpbl <= cpl;
          cpl  <= xc_in;
          mpl  <= x_in;
          mvl  <= vel_r;
        end
        KIND_FULL: begin
          cpbl <= cpl;
          cpl  <= xc_in;
          mpl  <= x_in;
          mvl  <= vel_r;
          maf  <= acc_r;
          caf  <= cacc_r;
        end
        default: ;
      endcase
    end

    if (cmd.done) begin
      cmd_accel   <= warm ? cacc_r : '0;
      meas_vel    <= warm ? vel_r : '0;
      meas_accel  <= warm ? acc_r : '0;
      force_error <= FERR_W'(ft_in) - FERR_W'(fm_in);
      warmed_up   <= warm;
    end
  end

endmodule

// ===== hw/rtl/defe_ctrl.sv =====
// Controller: item decode, warm-up flags and multiplier sequencing.
module defe_ctrl
  import defe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] func,
  input  logic       out_ready,
  output logic       in_ready,
  output logic       out_valid,
  output cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_LO   = 3'd2;
  localparam logic [2:0] ST_HI   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] op, op_next;
  logic       have_first, have_first_next;
  logic       have_second, have_second_next;
  logic       filter_started, filter_started_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next          = state;
    op_next             = op;
    have_first_next     = have_first;
    have_second_next    = have_second;
    filter_started_next = filter_started;
    cmd                 = '0;
    cmd.op              = op;
    if (!have_first) begin
      cmd.kind = KIND_FIRST;
    end else if (!have_second) begin
      cmd.kind = KIND_SECOND;
    end else begin
      cmd.kind = KIND_FULL;
    end

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_SAMPLE: begin
              cmd.capture = 1'b1;
              if (!have_first) begin
                state_next = ST_DONE;
              end else begin
                op_next    = OP_VEL;
                state_next = ST_LOAD;
              end
            end
            FUNC_SEED: begin
              cmd.seed            = 1'b1;
              have_first_next     = 1'b1;
              have_second_next    = 1'b0;
              filter_started_next = 1'b0;
            end
            FUNC_CLEAR: begin
              have_first_next     = 1'b0;
              have_second_next    = 1'b0;
              filter_started_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.mul_ld = 1'b1;
        state_next = ST_LO;
      end
      ST_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_HI;
      end
      ST_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.mul_fin = 1'b1;
        state_next  = ST_WB;
      end
      ST_WB: begin
        cmd.wb     = 1'b1;
        state_next = ST_LOAD;
        case (op)
          OP_VEL: begin
            if (!have_second) begin
              state_next = ST_DONE;
            end else begin
              op_next = OP_CACC;
            end
          end
          OP_CACC: op_next = OP_ACC;
          OP_ACC: begin
            if (filter_started) begin
              op_next = OP_EMA_M;
            end else begin
              state_next = ST_DONE;
            end
          end
          OP_EMA_M: op_next = OP_EMA_C;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.done   = 1'b1;
          state_next = ST_IDLE;
          if (!have_first) begin
            have_first_next = 1'b1;
          end else if (!have_second) begin
            have_second_next = 1'b1;
          end else begin
            filter_started_next = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      op             <= OP_VEL;
      have_first     <= 1'b0;
      have_second    <= 1'b0;
      filter_started <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      op             <= op_next;
      have_first     <= have_first_next;
      have_second    <= have_second_next;
      filter_started <= filter_started_next;
      out_valid      <= cmd.done || (out_valid && !out_ready);
    end
  end

endmodule

// ===== hw/rtl/derivative_ema_feature_estimator.sv =====
// Top level of the derivative and EMA feature estimator.
//
// Takes one word per sample (commanded and measured position, desired and
// measured force, Q16.16) and returns one result word with the measured
// velocity, the filtered measured and commanded accelerations (backward
// differences, saturated to 48 bits, smoothed by an exponential moving
// average seeded with the first raw value) and the exact force error. The
// first two samples after reset or a clear item are warm-up: derivatives
// read zero and warmed_up is low. Seed and clear words return no result.
// All products go through a single shared multiplier that steps each
// product through operand load, a 25x40 and a 24x40 partial product,
// rounding and saturation, and write-back; a sample needs no product for
// the first warm-up sample, one for the second, three for the first full
// sample and five once the filter runs. The result sits in an output
// register, so the next word is taken while a result waits; a sample only
// stalls at its end if the previous result has still not been taken.
// Configuration registers are written through cfg_we/cfg_index/cfg_data:
// 0 inv_step, 1 inv_step_sq, 2 filter_weight (values above 1.0 act as
// 1.0). The user must write them only while the block is idle, unchecked.
module derivative_ema_feature_estimator
  import defe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [K_W-1:0]           cfg_data,
  // input word
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               func,
  input  logic signed [POS_W-1:0]  cmd_pos,
  input  logic signed [POS_W-1:0]  meas_pos,
  input  logic signed [VAL_W-1:0]  seed_vel,
  input  logic signed [POS_W-1:0]  force_target,
  input  logic signed [POS_W-1:0]  force_measured,
  // result word
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  cmd_accel,
  output logic signed [VAL_W-1:0]  meas_vel,
  output logic signed [VAL_W-1:0]  meas_accel,
  output logic signed [FERR_W-1:0] force_error,
  output logic                     warmed_up
);

  cmd_t cmd;

  // Sequencer: decodes words, keeps warm-up flags, steps the multiplier
  defe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Arithmetic, history and the result register
  defe_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .cmd_pos        (cmd_pos),
    .meas_pos       (meas_pos),
    .seed_vel       (seed_vel),
    .force_target   (force_target),
    .force_measured (force_measured),
    .cmd_accel      (cmd_accel),
    .meas_vel       (meas_vel),
    .meas_accel     (meas_accel),
    .force_error    (force_error),
    .warmed_up      (warmed_up)
  );

  // Never overwrite a result word that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.done |-> (!out_valid || out_ready))
    else $error("result word overwritten while pending");

  // Seed, clear and unused words complete at once and give no result
  a_non_sample_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func != FUNC_SAMPLE) |=> (in_ready && !cmd.done))
    else $error("non-sample word started a computation");

  // Warm-up results carry zero derivatives
  a_warmup_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !warmed_up) |-> (meas_vel == '0 && meas_accel == '0 && cmd_accel == '0))
    else $error("nonzero derivative during warm-up");

  // A sample word is always taken into the datapath when accepted
  a_capture: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == FUNC_SAMPLE) |-> cmd.capture)
    else $error("accepted sample word not captured");

endmodule
